### src/assert_macros.svh
// Assertion macros shared by the slot manager RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");

`endif

### src/bpsm_pkg.sv
// Package for the buffer pool slot manager: default sizes, operation codes
// and the request and response payload structs. No dependencies.
package bpsm_pkg;

   localparam int SLOTS_DEF    = 8;
   localparam int AGE_BITS_DEF = 16;
   localparam int PAGE_ADDR_W  = 32;
   localparam int SLOT_FIELD_W = 3;

   typedef enum logic {
      OP_GET     = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef struct packed {
      op_type                 operation;
      logic [PAGE_ADDR_W-1:0] page_addr;
   } req_type;

   typedef struct packed {
      logic [SLOT_FIELD_W-1:0] slot;
      logic                    hit;
      logic                    fetch_needed;
      logic                    writeback_needed;
      logic [PAGE_ADDR_W-1:0]  writeback_addr;
   } rsp_type;

endpackage

### src/bpsm_victim.sv
// Eviction choice for the slot manager: oldest slot, lowest index on a tie.
// Depends on nothing but its parameters.
module bpsm_victim #(
   parameter int SLOTS    = 8,
   parameter int AGE_BITS = 16
) (
   input  logic [SLOTS-1:0][AGE_BITS-1:0] age,
   output logic [SLOTS-1:0]               pick
);

   // A slot wins when it is strictly older than every lower slot and at
   // least as old as every higher one; exactly one slot can meet both.
   always_comb begin
      logic win;
      for (int i = 0; i < SLOTS; i++) begin
         win = 1'b1;
         for (int j = 0; j < SLOTS; j++) begin
            if (j < i) begin
               win = win & (age[i] > age[j]);
            end else if (j > i) begin
               win = win & (age[i] >= age[j]);
            end
         end
         pick[i] = win;
      end
   end

endmodule

### src/buffer_pool_slot_manager_core.sv
// Buffer pool slot manager top level: lookup, replacement and pin tracking.
// Depends on bpsm_pkg, bpsm_victim and assert_macros.svh.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  bpsm_pkg::req_type (get or release)
//   rsp      out        rsp_valid/rsp_stall  bpsm_pkg::rsp_type (one per request)
//
// A request is held in the input register and its response is then loaded into
// the output register once that is free or drains: one transfer per cycle unless
// rsp_stall holds it; one single pass of tag compare and age selection sets the rate.
// Reset (synchronous) empties all slots, clears pins and ages; no clearing pass.
// A stalled response holds the pipe; the input register still takes one more item.
module buffer_pool_slot_manager_core #(
   parameter int SLOTS    = bpsm_pkg::SLOTS_DEF,
   parameter int AGE_BITS = bpsm_pkg::AGE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bpsm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bpsm_pkg::rsp_type rsp_data
);
   import bpsm_pkg::*;

`include "assert_macros.svh"

   localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

   // Pipeline registers.
   logic    req_valid_ff, req_valid_in;
   req_type req_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Slot state.
   logic [PAGE_ADDR_W-1:0]        tag_ff [SLOTS];
   logic [SLOTS-1:0]              valid_ff, valid_in;
   logic [SLOTS-1:0]              pinned_ff, pinned_in;
   logic [SLOTS-1:0][AGE_BITS-1:0] age_ff, age_in;

   // Decision signals.
   logic                           advance;
   logic                           is_get;
   logic                           any_match, any_free;
   logic                           get_hit, get_miss, rel_hit;
   logic [SLOTS-1:0]               match_vec, hit_vec, free_vec, victim_vec, claim_vec;
   logic [SLOTS-1:0]               sel_vec;
   logic [SLOTS-1:0][AGE_BITS-1:0] aged;
   logic [PAGE_ADDR_W-1:0]         victim_tag;
   logic [SLOT_FIELD_W-1:0]        slot_field;

   // Handshake: the request moves on when the output register is free or drains.
   assign advance      = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = req_valid_ff && !advance;
   assign req_valid_in = (req_valid && !req_stall) || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   // Tag compare, lowest matching slot, highest free slot and saturated ages.
   always_comb begin
      logic found_m;
      logic found_f;
      found_m = 1'b0;
      found_f = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         match_vec[i] = valid_ff[i] && (tag_ff[i] == req_ff.page_addr);
         hit_vec[i]   = match_vec[i] && !found_m;
         found_m      = found_m | match_vec[i];
         aged[i]      = (age_ff[i] == AGE_MAX) ? age_ff[i] : age_ff[i] + 1'b1;
      end
      for (int i = SLOTS - 1; i >= 0; i--) begin
         free_vec[i] = !pinned_ff[i] && !found_f;
         found_f     = found_f | !pinned_ff[i];
      end
   end

   // Oldest slot after aging, used only when every slot is pinned.
   bpsm_victim #(
      .SLOTS    (SLOTS),
      .AGE_BITS (AGE_BITS)
   ) u_victim (
      .age  (aged),
      .pick (victim_vec)
   );

   assign any_match = |match_vec;
   assign any_free  = |(~pinned_ff);
   assign is_get    = (req_ff.operation == OP_GET);
   assign claim_vec = any_free ? free_vec : victim_vec;
   assign get_hit   = advance && is_get && any_match;
   assign get_miss  = advance && is_get && !any_match;
   assign rel_hit   = advance && !is_get && any_match;
   assign sel_vec   = (is_get && !any_match) ? claim_vec : hit_vec;

   // Slot number and the victim's old tag, both picked by one-hot vectors.
   always_comb begin
      slot_field = '0;
      victim_tag = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (sel_vec[i]) begin
            slot_field = slot_field | SLOT_FIELD_W'(i);
         end
         if (victim_vec[i] && valid_ff[i]) begin
            victim_tag = victim_tag | tag_ff[i];
         end
      end
   end

   // Response fields.
   always_comb begin
      rsp_in.slot         = slot_field;
      rsp_in.hit          = any_match;
      rsp_in.fetch_needed = is_get && !any_match;
      if (is_get) begin
         rsp_in.writeback_needed = !any_match && !any_free && |(victim_vec & valid_ff);
         rsp_in.writeback_addr   = (!any_match && !any_free) ? victim_tag : '0;
      end else begin
         rsp_in.writeback_needed = any_match;
         rsp_in.writeback_addr   = any_match ? req_ff.page_addr : '0;
      end
   end

   // Next slot state.
   always_comb begin
      valid_in  = valid_ff;
      pinned_in = pinned_ff;
      age_in    = age_ff;
      if (get_hit) begin
         pinned_in = pinned_ff | hit_vec;
         for (int i = 0; i < SLOTS; i++) begin
            age_in[i] = hit_vec[i] ? '0 : aged[i];
         end
      end else if (get_miss) begin
         valid_in  = valid_ff | claim_vec;
         pinned_in = pinned_ff | claim_vec;
         for (int i = 0; i < SLOTS; i++) begin
            age_in[i] = claim_vec[i] ? '0 : aged[i];
         end
      end else if (rel_hit) begin
         pinned_in = pinned_ff & ~hit_vec;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         pinned_ff    <= '0;
         age_ff       <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         pinned_ff    <= pinned_in;
         age_ff       <= age_in;
      end
   end

   // Payload registers and tags.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (get_miss && claim_vec[i]) begin
            tag_ff[i] <= req_ff.page_addr;
         end
      end
   end

   // Checks.
   `CHK_IMPL(a_victim_onehot, clock, reset, 1'b1, $onehot(victim_vec))
   `CHK_NEXT(a_claim_pinned, clock, reset, get_miss, (valid_ff & pinned_ff & $past(claim_vec)) == $past(claim_vec))
   `CHK_NEXT(a_rsp_loaded, clock, reset, advance, rsp_valid_ff)

endmodule

### tb/sv/bpsm_slot_checker.sv
`timescale 1ns / 1ps
// Checker for the buffer pool slot manager: watches the request and response channels,
// predicts every response from its own copy of the slot state and compares field by field.
// Depends on bpsm_pkg for the payload types and the operation codes.
module bpsm_slot_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  bpsm_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  bpsm_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                outstanding
);
   import bpsm_pkg::*;

   localparam int SLOTS    = SLOTS_DEF;
   localparam int AGE_BITS = AGE_BITS_DEF;

   // Shadow copy of the slot table.
   logic [PAGE_ADDR_W-1:0] page_tag [SLOTS];
   logic                   page_held [SLOTS];
   logic                   page_pinned [SLOTS];
   logic [AGE_BITS-1:0]    page_age [SLOTS];

   rsp_type expected_rsp [$];
   rsp_type oldest_rsp;
   int      mismatch_total = 0;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // Ages every slot except the one given, saturating at the top of the range.
   function automatic void age_slots(input int keep);
      int i;
      for (i = 0; i < SLOTS; i++) begin
         if (i != keep && page_age[i] != '1) page_age[i] = page_age[i] + 1'b1;
      end
   endfunction

   // Applies one get or release to the shadow table and returns the response it causes.
   function automatic rsp_type lookup_and_replace(input req_type r);
      rsp_type o;
      int      i;
      int      match_idx;
      int      free_idx;
      int      pick;
      o         = '0;
      match_idx = -1;
      free_idx  = -1;
      pick      = 0;
      for (i = SLOTS - 1; i >= 0; i--) begin
         if (page_held[i] && page_tag[i] == r.page_addr) match_idx = i;
      end
      if (r.operation == OP_RELEASE) begin
         // A release of a held page writes it back and unpins it, pinned or not.
         if (match_idx >= 0) begin
            pick                   = match_idx;
            page_pinned[match_idx] = 1'b0;
            o.hit                  = 1'b1;
            o.writeback_needed     = 1'b1;
            o.writeback_addr       = r.page_addr;
         end
      end else if (match_idx >= 0) begin
         pick = match_idx;
         age_slots(match_idx);
         page_age[match_idx]    = '0;
         page_pinned[match_idx] = 1'b1;
         o.hit                  = 1'b1;
      end else begin
         age_slots(-1);
         for (i = 0; i < SLOTS; i++) begin
            if (!page_pinned[i]) free_idx = i;
         end
         if (free_idx >= 0) begin
            pick = free_idx;
         end else begin
            // Every slot is pinned: the oldest one goes, lowest index on a tie.
            for (i = 1; i < SLOTS; i++) begin
               if (page_age[i] > page_age[pick]) pick = i;
            end
            if (page_held[pick]) begin
               o.writeback_needed = 1'b1;
               o.writeback_addr   = page_tag[pick];
            end
         end
         page_tag[pick]    = r.page_addr;
         page_held[pick]   = 1'b1;
         page_pinned[pick] = 1'b1;
         page_age[pick]    = '0;
         o.fetch_needed    = 1'b1;
      end
      o.slot = SLOT_FIELD_W'(pick);
      return o;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
         mismatch_total++;
      end
   endfunction

   // Responses are compared before the request of the same edge is predicted, so a
   // response can never be matched against an expectation that arrived with it.
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            page_tag[i]    = '0;
            page_held[i]   = 1'b0;
            page_pinned[i] = 1'b0;
            page_age[i]    = '0;
         end
         expected_rsp.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("response transfer with no response expected");
               mismatch_total++;
            end else begin
               oldest_rsp = expected_rsp.pop_front();
               check_field("slot", 32'(oldest_rsp.slot), 32'(rsp_data.slot));
               check_field("hit", 32'(oldest_rsp.hit), 32'(rsp_data.hit));
               check_field("fetch_needed", 32'(oldest_rsp.fetch_needed),
                           32'(rsp_data.fetch_needed));
               check_field("writeback_needed", 32'(oldest_rsp.writeback_needed),
                           32'(rsp_data.writeback_needed));
               check_field("writeback_addr", oldest_rsp.writeback_addr,
                           rsp_data.writeback_addr);
            end
         end
         if (req_valid && !req_stall) expected_rsp.push_back(lookup_and_replace(req_data));
      end
      fail_count  <= mismatch_total;
      outstanding <= expected_rsp.size();
   end

endmodule

### tb/sv/tb_buffer_pool_slot_manager_core.sv
`timescale 1ns / 1ps
// Testbench top for the buffer pool slot manager: clock, reset, request and response
// stimulus with random idling, watchdog and verdict. Depends on bpsm_pkg and bpsm_slot_checker.
module tb_buffer_pool_slot_manager_core;
   import bpsm_pkg::*;

   localparam int RANDOM_ITEMS = 1790;
   localparam int HAMMER_GETS  = 40;
   localparam int LONG_HOLD    = 300;
   localparam int QUIET_LIMIT  = 2000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      fail_count;
   int      outstanding;

   // Idling control shared by the two sides.
   bit burst         = 1'b0;
   bit hold_rsp_long = 1'b0;
   int req_mode      = 2;
   int quiet_cycles  = 0;

   logic [PAGE_ADDR_W-1:0] addr_pool [16];
   int                     pool_size;
   int                     release_pct;

   buffer_pool_slot_manager_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   bpsm_slot_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Mode 0 never waits, mode 1 waits now and then, mode 2 waits on most items.
   function automatic int idle_draw(input int mode);
      if (mode == 0) return 0;
      if (mode == 1 && $urandom_range(0, 3) != 0) return 0;
      return $urandom_range(0, 14);
   endfunction

   // Offers one request and returns at the edge where it is transferred.
   task automatic send_req(input op_type op, input logic [PAGE_ADDR_W-1:0] addr);
      int gap;
      gap = burst ? 0 : idle_draw(req_mode);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= req_type'{operation: op, page_addr: addr};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Stops offering and waits until every predicted response has been transferred.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Response side: one stall draw per response, plus one long hold-off on request.
   initial begin
      int wait_n;
      int served;
      int rsp_mode;
      served    = 0;
      rsp_mode  = 2;
      rsp_stall <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (served % 64 == 0) rsp_mode = $urandom_range(0, 2);
         wait_n = burst ? 0 : idle_draw(rsp_mode);
         if (hold_rsp_long) begin
            wait_n        = LONG_HOLD;
            hold_rsp_long = 1'b0;
         end
         if (wait_n > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         served++;
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_buffer_pool_slot_manager_core: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Request side: directed cases, a run of hits on one page, then random traffic.
   initial begin
      op_type                 op;
      logic [PAGE_ADDR_W-1:0] addr;
      int                     n;
      int                     k;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Fill all eight slots with extreme addresses; misses claim slots from the top down.
      send_req(OP_GET, 32'h0000_0000);
      send_req(OP_GET, 32'hFFFF_FFFF);
      send_req(OP_GET, 32'h8000_0000);
      send_req(OP_GET, 32'h0000_0001);
      send_req(OP_GET, 32'h7FFF_FFFF);
      send_req(OP_GET, 32'hAAAA_AAAA);
      send_req(OP_GET, 32'h5555_5555);
      send_req(OP_GET, 32'h1234_5678);
      // Hit, then a miss with every slot pinned evicts the oldest page.
      send_req(OP_GET, 32'hFFFF_FFFF);
      send_req(OP_GET, 32'hDEAD_BEEF);
      // Release, release of an already unpinned page, release with no match.
      send_req(OP_RELEASE, 32'h5555_5555);
      send_req(OP_RELEASE, 32'h5555_5555);
      send_req(OP_RELEASE, 32'h0BAD_F00D);
      // A miss takes the freed slot; a get on an unpinned held page is a hit.
      send_req(OP_GET, 32'hCAFE_F00D);
      send_req(OP_RELEASE, 32'hFFFF_FFFF);
      send_req(OP_GET, 32'hFFFF_FFFF);
      send_req(OP_GET, 32'h0000_0000);
      drain_responses();

      // Hammer one page back to back so every other slot grows old, then miss twice.
      burst = 1'b1;
      for (k = 0; k < HAMMER_GETS; k++) send_req(OP_GET, 32'h0000_0000);
      send_req(OP_GET, 32'h1357_9BDF);
      send_req(OP_GET, 32'h2468_ACE0);
      drain_responses();
      burst = 1'b0;

      // Random traffic over a small address pool so pages are reused, with some noise.
      pool_size   = 8;
      release_pct = 35;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) begin
            req_mode = $urandom_range(0, 2);
            case ($urandom_range(0, 2))
               0:       release_pct = 10;
               1:       release_pct = 35;
               default: release_pct = 60;
            endcase
            if (n == 0 || $urandom_range(0, 3) == 0) begin
               for (k = 0; k < 16; k++) addr_pool[k] = $urandom();
            end
            pool_size = $urandom_range(4, 16);
         end
         if (n == 600) begin
            // The response side holds off while requests keep coming back to back.
            hold_rsp_long = 1'b1;
            req_mode      = 0;
         end
         if (n == 1200) drain_responses();
         op   = ($urandom_range(0, 99) < release_pct) ? OP_RELEASE : OP_GET;
         addr = ($urandom_range(0, 9) == 0) ? $urandom()
                                            : addr_pool[$urandom_range(0, pool_size - 1)];
         send_req(op, addr);
      end

      drain_responses();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_buffer_pool_slot_manager_core: clean");
      end else begin
         $display("tb_buffer_pool_slot_manager_core: errors");
      end
      $finish;
   end

endmodule
